// ===== rtl/mpos_pkg.sv =====
// Shared types and constants for the modem power-on sequencer.
// No dependencies.
`timescale 1ns / 1ps

package mpos_pkg;

  localparam int unsigned CntW = 16;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [2:0] phase_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] action_t;
  typedef logic [2:0] cfg_idx_t;

  localparam phase_t PH_IDLE   = 3'd0;
  localparam phase_t PH_OFF    = 3'd1;
  localparam phase_t PH_SETTLE = 3'd2;
  localparam phase_t PH_PULSE  = 3'd3;
  localparam phase_t PH_POLL   = 3'd4;

  localparam status_t ST_IDLE   = 2'd0;
  localparam status_t ST_SEQ    = 2'd1;
  localparam status_t ST_READY  = 2'd2;
  localparam status_t ST_FAILED = 2'd3;

  localparam action_t ACT_TICK     = 2'd0;
  localparam action_t ACT_BOOT     = 2'd1;
  localparam action_t ACT_RECOVERY = 2'd2;

  localparam cfg_idx_t REG_OFF      = 3'd0;
  localparam cfg_idx_t REG_SETTLE   = 3'd1;
  localparam cfg_idx_t REG_PULSE    = 3'd2;
  localparam cfg_idx_t REG_POLL     = 3'd3;
  localparam cfg_idx_t REG_TIMEOUT  = 3'd4;

  localparam cnt_t OFF_RST     = 16'd200;
  localparam cnt_t SETTLE_RST  = 16'd500;
  localparam cnt_t PULSE_RST   = 16'd4500;
  localparam cnt_t POLL_RST    = 16'd50;
  localparam cnt_t TIMEOUT_RST = 16'd15000;

  typedef struct packed {
    logic    power_enable;
    logic    onoff_drive;
    status_t status;
  } result_t;

  function automatic cnt_t inc_sat(input cnt_t v);
    return (v == '1) ? v : cnt_t'(v + 1'b1);
  endfunction

  function automatic logic interval_done(input cnt_t count, input cnt_t limit);
    cnt_t lim;
    lim = (limit == '0) ? cnt_t'(1) : limit;
    return count >= lim;
  endfunction

endpackage

// ===== rtl/modem_power_on_sequencer_unit.sv =====
// Modem power-on sequencer top level: phase/counter state, register file
// and a two-entry output stage. Depends on mpos_pkg.
`timescale 1ns / 1ps

// Takes one item per clock: a millisecond tick or a start command, with
// the sampled ready pin. Each item yields exactly one result holding the
// power and on/off line levels and the status after that item. The phase
// update is combinational counter compares; the result lands in an output
// register backed by a skid register, so an item is taken every cycle while
// the result side keeps up, and in_stall rises only when both output
// entries are full. The user must ensure timing registers are written
// through cfg_* only while the block is idle; the block does not check it.
module modem_power_on_sequencer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mpos_pkg::action_t  in_action,
  input  logic               in_ready_pin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_power_enable,
  output logic               out_onoff_drive,
  output mpos_pkg::status_t  out_status,
  input  logic               cfg_we,
  input  mpos_pkg::cfg_idx_t cfg_index,
  input  mpos_pkg::cnt_t     cfg_wdata
);
  import mpos_pkg::*;

  cnt_t off_r, settle_r, pulse_r, poll_r, timeout_r;

  phase_t  phase_r, phase_nxt;
  cnt_t    phase_cnt_r, phase_cnt_nxt;
  cnt_t    wait_cnt_r, wait_cnt_nxt;
  logic    one_shot_r, one_shot_nxt;
  status_t outcome_r, outcome_nxt;

  result_t res_nxt, main_r, skid_r;
  logic    main_v_r, skid_v_r;
  logic    accept, is_start;
  cnt_t    pc_inc, wc_inc;

  assign in_stall = skid_v_r;
  assign accept   = in_valid && !skid_v_r;
  assign is_start = (in_action == ACT_BOOT) || (in_action == ACT_RECOVERY);
  assign pc_inc   = inc_sat(phase_cnt_r);
  assign wc_inc   = inc_sat(wait_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r     <= OFF_RST;
      settle_r  <= SETTLE_RST;
      pulse_r   <= PULSE_RST;
      poll_r    <= POLL_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFF:     off_r     <= cfg_wdata;
        REG_SETTLE:  settle_r  <= cfg_wdata;
        REG_PULSE:   pulse_r   <= cfg_wdata;
        REG_POLL:    poll_r    <= cfg_wdata;
        REG_TIMEOUT: timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    phase_cnt_nxt = phase_cnt_r;
    wait_cnt_nxt  = wait_cnt_r;
    one_shot_nxt  = one_shot_r;
    outcome_nxt   = outcome_r;
    if (is_start) begin
      if (phase_r == PH_IDLE) begin
        one_shot_nxt  = (in_action == ACT_RECOVERY);
        outcome_nxt   = ST_SEQ;
        wait_cnt_nxt  = '0;
        phase_nxt     = PH_OFF;
        phase_cnt_nxt = '0;
      end
    end else begin
      case (phase_r)
        PH_OFF: begin
          phase_cnt_nxt = pc_inc;
          if (interval_done(pc_inc, off_r)) begin
            phase_nxt     = PH_SETTLE;
            phase_cnt_nxt = '0;
          end
        end
        PH_SETTLE: begin
          phase_cnt_nxt = pc_inc;
          if (interval_done(pc_inc, settle_r)) begin
            phase_nxt     = PH_PULSE;
            phase_cnt_nxt = '0;
          end
        end
        PH_PULSE: begin
          phase_cnt_nxt = pc_inc;
          if (interval_done(pc_inc, pulse_r)) begin
            phase_nxt     = PH_POLL;
            phase_cnt_nxt = '0;
            wait_cnt_nxt  = '0;
          end
        end
        PH_POLL: begin
          phase_cnt_nxt = pc_inc;
          wait_cnt_nxt  = wc_inc;
          if (interval_done(pc_inc, poll_r)) begin
            phase_cnt_nxt = '0;
            if (!in_ready_pin) begin
              outcome_nxt = ST_READY;
              phase_nxt   = PH_IDLE;
            end else if (interval_done(wc_inc, timeout_r)) begin
              if (one_shot_r) begin
                outcome_nxt = ST_FAILED;
                phase_nxt   = PH_IDLE;
              end else begin
                phase_nxt = PH_OFF;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_nxt.status      = outcome_nxt;
    res_nxt.onoff_drive = (phase_nxt == PH_PULSE);
    case (phase_nxt)
      PH_OFF:  res_nxt.power_enable = 1'b0;
      PH_IDLE: res_nxt.power_enable = (outcome_nxt != ST_IDLE);
      default: res_nxt.power_enable = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      phase_cnt_r <= '0;
      wait_cnt_r  <= '0;
      one_shot_r  <= 1'b0;
      outcome_r   <= ST_IDLE;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      phase_cnt_r <= phase_cnt_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      one_shot_r  <= one_shot_nxt;
      outcome_r   <= outcome_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (!out_stall) begin
        main_r   <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (accept) begin
      if (!main_v_r || !out_stall) begin
        main_r   <= res_nxt;
        main_v_r <= 1'b1;
      end else begin
        skid_r   <= res_nxt;
        skid_v_r <= 1'b1;
      end
    end else if (main_v_r && !out_stall) begin
      main_v_r <= 1'b0;
    end
  end

  assign out_valid        = main_v_r;
  assign out_power_enable = main_r.power_enable;
  assign out_onoff_drive  = main_r.onoff_drive;
  assign out_status       = main_r.status;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held without output entry");

  a_running_is_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (outcome_r == ST_SEQ))
    else $error("active phase without sequencing status");

  a_pulse_only_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_onoff_drive) |-> (out_power_enable && out_status == ST_SEQ))
    else $error("on/off pulse outside a running sequence");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> !skid_v_r)
    else $error("skid entry not drained");

endmodule
